### design/fresnel_dielectric_reflectance_core_defines.svh
// Assertion macros for the Fresnel reflectance core.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_CORE_DEFINES_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FDR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fdr_pkg.sv
// Shared constants for the Fresnel reflectance core.
`timescale 1ns / 1ps
package fdr_pkg;
    // internal fraction bits never exceed this
    localparam int MAX_WORK_BITS = 24;
endpackage

### design/fresnel_dielectric_reflectance_core.sv
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// W = min(FRAC_BITS,24) is the working fraction width.
// Throughput: one word per cycle while the output word is not held; the
// square root and the three dividers are unrolled one digit per stage, so no
// unit is shared between words. A stalled output word freezes every stage.
// rst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`include "fresnel_dielectric_reflectance_core_defines.svh"

module fresnel_dielectric_reflectance_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic signed [FRAC_BITS+1:0] cos_incident,
    input  logic [FRAC_BITS+3:0]        rel_index,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [FRAC_BITS:0]          reflectance,
    output logic                        total_internal
);
    import fdr_pkg::*;

    // Widths: WB working fraction bits, CW cosine-like values (<= one),
    // EW index-like values (< 16), RW squares of EW, NW divider numerators.
    localparam int FB   = FRAC_BITS;
    localparam int WB   = (FB < MAX_WORK_BITS) ? FB : MAX_WORK_BITS;
    localparam int DROP = FB - WB;
    localparam int CW   = WB + 1;
    localparam int EW   = WB + 4;
    localparam int RW   = 2 * EW;
    localparam int NW   = EW + WB;
    localparam int QW   = WB + 1;
    localparam int DW   = EW + 1;
    localparam int PW   = 2 * WB + 9;

    localparam logic [CW-1:0]        ONE_C   = {1'b1, {WB{1'b0}}};
    localparam logic signed [FB+1:0] ONE_S   = {2'b01, {FB{1'b0}}};
    localparam logic [FB:0]          ONE_OUT = {1'b1, {FB{1'b0}}};

    // Per-word data that rides along the long iterative sections.
    typedef struct packed {
        logic          lv;   // ray leaves the medium (index inverted)
        logic          tir;  // total internal reflection
        logic [CW-1:0] c;    // |cos| in working precision
        logic [EW-1:0] e;    // relative index in working precision
        logic [EW-1:0] a;    // e*c
    } side_t;

    // One global advance: the whole pipe moves unless the output word is
    // held by the receiver.
    logic out_v_reg;
    logic adv;
    assign adv        = !out_v_reg || !result_stall;
    assign item_stall = !adv;

    // ---------------- Stage 1: clamp, fold sign, reduce precision ----------
    logic signed [FB+1:0] cos_cl;
    logic                 lv_in;
    logic [FB+1:0]        mag_in;
    logic [CW-1:0]        c_in;
    logic [EW-1:0]        e_in;

    always_comb
    begin
        if (cos_incident > ONE_S)
            cos_cl = ONE_S;
        else if (cos_incident < -ONE_S)
            cos_cl = -ONE_S;
        else
            cos_cl = cos_incident;
        lv_in  = cos_cl[FB+1];
        mag_in = lv_in ? (FB+2)'(0) - cos_cl : cos_cl;
        c_in   = CW'(mag_in[FB:0] >> DROP);
        e_in   = EW'(rel_index >> DROP);
    end

    logic          v1_reg;
    logic [CW-1:0] c1_reg;
    logic [EW-1:0] e1_reg;
    logic          lv1_reg;

    // ---------------- Stage 2: c*c, e*c, e*e -------------------------------
    logic              v2_reg;
    logic [2*CW-1:0]   cc2_reg;
    logic [EW+CW-1:0]  ec2_reg;
    logic [RW-1:0]     ee2_reg;
    logic [CW-1:0]     c2_reg;
    logic [EW-1:0]     e2_reg;
    logic              lv2_reg;

    // ---------------- Stage 3: sin^2 of incidence and e*c ------------------
    logic              v3_reg;
    logic [CW-1:0]     s3_reg;
    logic [EW-1:0]     a3_reg;
    logic [RW-1:0]     ee3_reg;
    logic [CW-1:0]     c3_reg;
    logic [EW-1:0]     e3_reg;
    logic              lv3_reg;

    // ---------------- Stage 4: entering test, leaving product --------------
    logic [RW-1:0] sw4;
    logic          tir_en4;
    logic [RW-1:0] dif4;
    logic [PW-1:0] prod4;

    assign sw4     = RW'({s3_reg, {WB{1'b0}}});
    assign tir_en4 = sw4 >= ee3_reg;
    assign dif4    = ee3_reg - sw4;
    assign prod4   = PW'(s3_reg) * PW'(ee3_reg[RW-1:WB]);

    logic          v4_reg;
    logic [RW-1:0] dif4_reg;
    logic [PW-1:0] prod4_reg;
    side_t         sd4_reg;

    // ---------------- Stage 5: leaving test, pick the radicand -------------
    logic [WB+8:0] tt5;
    logic          tir_lv5;
    logic [RW-1:0] rad_lv5;
    side_t         sd5;
    logic [RW-1:0] rad5;

    always_comb
    begin
        tt5     = prod4_reg[PW-1:WB];
        tir_lv5 = tt5 >= (WB+9)'(ONE_C);
        rad_lv5 = RW'({ONE_C - tt5[CW-1:0], {WB{1'b0}}});
        sd5     = sd4_reg;
        if (sd4_reg.lv)
        begin
            sd5.tir = tir_lv5;
            rad5    = rad_lv5;
        end
        else
        begin
            rad5 = dif4_reg;
        end
    end

    logic          v5_reg;
    logic [RW-1:0] rad5_reg;
    side_t         sd5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg    <= c_in;
            e1_reg    <= e_in;
            lv1_reg   <= lv_in;

            cc2_reg   <= (2*CW)'(c1_reg) * (2*CW)'(c1_reg);
            ec2_reg   <= (EW+CW)'(e1_reg) * (EW+CW)'(c1_reg);
            ee2_reg   <= RW'(e1_reg) * RW'(e1_reg);
            c2_reg    <= c1_reg;
            e2_reg    <= e1_reg;
            lv2_reg   <= lv1_reg;

            s3_reg    <= ONE_C - CW'(cc2_reg >> WB);
            a3_reg    <= EW'(ec2_reg >> WB);
            ee3_reg   <= ee2_reg;
            c3_reg    <= c2_reg;
            e3_reg    <= e2_reg;
            lv3_reg   <= lv2_reg;

            dif4_reg  <= dif4;
            prod4_reg <= prod4;
            sd4_reg   <= '{lv: lv3_reg, tir: tir_en4, c: c3_reg, e: e3_reg, a: a3_reg};

            rad5_reg  <= rad5;
            sd5_reg   <= sd5;
        end
    end

    // ---------------- Square root: two radicand bits per stage -------------
    // Entering gives g = sqrt(e^2 - s), leaving gives cos_t directly.
    logic          sq_v_reg  [0:EW-1];
    logic [EW-1:0] sq_rt_reg [0:EW-1];
    logic [EW-1:0] sq_rm_reg [0:EW-1];
    logic [RW-1:0] sq_rd_reg [0:EW-1];
    side_t         sq_sd_reg [0:EW-1];

    genvar k, j;
    generate
        for (k = 0; k < EW; k++)
        begin : g_sqrt
            logic          v_i;
            logic [EW-1:0] rt_i;
            logic [EW-1:0] rm_i;
            logic [RW-1:0] rd_i;
            side_t         sd_i;
            logic [EW+1:0] cur;
            logic [EW+1:0] trial;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign v_i  = v5_reg;
                assign rt_i = '0;
                assign rm_i = '0;
                assign rd_i = rad5_reg;
                assign sd_i = sd5_reg;
            end
            else
            begin : g_next
                assign v_i  = sq_v_reg[k-1];
                assign rt_i = sq_rt_reg[k-1];
                assign rm_i = sq_rm_reg[k-1];
                assign rd_i = sq_rd_reg[k-1];
                assign sd_i = sq_sd_reg[k-1];
            end

            assign cur   = {rm_i, rd_i[RW-1:RW-2]};
            assign trial = {rt_i, 2'b01};
            assign ge    = cur >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_v_reg[k] <= 1'b0;
                else if (adv)
                    sq_v_reg[k] <= v_i;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_rt_reg[k] <= {rt_i[EW-2:0], ge};
                    sq_rm_reg[k] <= EW'(ge ? cur - trial : cur);
                    sq_rd_reg[k] <= {rd_i[RW-3:0], 2'b00};
                    sq_sd_reg[k] <= sd_i;
                end
            end
        end
    endgenerate

    // ---------------- Divider: cos_t = (g << W) / e, one bit per stage -----
    logic          d1_v_reg   [0:QW-1];
    logic [NW-1:0] d1_rem_reg [0:QW-1];
    logic [QW-1:0] d1_q_reg   [0:QW-1];
    logic [EW-1:0] d1_g_reg   [0:QW-1];
    side_t         d1_sd_reg  [0:QW-1];

    generate
        for (k = 0; k < QW; k++)
        begin : g_div1
            localparam int B = QW - 1 - k;
            logic          v_i;
            logic [NW-1:0] rem_i;
            logic [QW-1:0] q_i;
            logic [EW-1:0] g_i;
            side_t         sd_i;
            logic [NW-1:0] dsh;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign v_i   = sq_v_reg[EW-1];
                assign rem_i = {sq_rt_reg[EW-1], {WB{1'b0}}};
                assign q_i   = '0;
                assign g_i   = sq_rt_reg[EW-1];
                assign sd_i  = sq_sd_reg[EW-1];
            end
            else
            begin : g_next
                assign v_i   = d1_v_reg[k-1];
                assign rem_i = d1_rem_reg[k-1];
                assign q_i   = d1_q_reg[k-1];
                assign g_i   = d1_g_reg[k-1];
                assign sd_i  = d1_sd_reg[k-1];
            end

            assign dsh = NW'(sd_i.e) << B;
            assign ge  = rem_i >= dsh;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    d1_v_reg[k] <= 1'b0;
                else if (adv)
                    d1_v_reg[k] <= v_i;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    d1_rem_reg[k] <= ge ? rem_i - dsh : rem_i;
                    d1_q_reg[k]   <= {q_i[QW-2:0], ge};
                    d1_g_reg[k]   <= g_i;
                    d1_sd_reg[k]  <= sd_i;
                end
            end
        end
    endgenerate

    // ---------------- Stage M: pick cos_t, leaving product e*cos_t ---------
    logic [EW-1:0] gm;
    side_t         sdm;
    assign gm  = d1_g_reg[QW-1];
    assign sdm = d1_sd_reg[QW-1];

    logic             v6_reg;
    logic [CW-1:0]    ct6_reg;
    logic [EW+CW-1:0] pm6_reg;
    logic [EW-1:0]    g6_reg;
    side_t            sd6_reg;

    // ---------------- Stage P: form the two ratio pairs --------------------
    logic [EW-1:0] p2;
    logic [EW-1:0] x7 [0:1];
    logic [EW-1:0] y7 [0:1];
    logic [DW-1:0] sum7 [0:1];
    logic [EW-1:0] dif7 [0:1];

    always_comb
    begin
        p2    = sd6_reg.lv ? EW'(pm6_reg >> WB) : g6_reg;
        x7[0] = sd6_reg.a;
        y7[0] = EW'(ct6_reg);
        x7[1] = EW'(sd6_reg.c);
        y7[1] = p2;
        for (int i = 0; i < 2; i++)
        begin
            sum7[i] = DW'(x7[i]) + DW'(y7[i]);
            dif7[i] = (x7[i] > y7[i]) ? x7[i] - y7[i] : y7[i] - x7[i];
        end
    end

    logic          v7_reg;
    logic          tir7_reg;
    logic [NW-1:0] n7_reg [0:1];
    logic [DW-1:0] dn7_reg [0:1];
    logic          z7_reg [0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= d1_v_reg[QW-1];
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ct6_reg  <= sdm.lv ? gm[CW-1:0] : d1_q_reg[QW-1];
            pm6_reg  <= (EW+CW)'(sdm.e) * (EW+CW)'(gm[CW-1:0]);
            g6_reg   <= gm;
            sd6_reg  <= sdm;

            tir7_reg <= sd6_reg.tir;
            for (int i = 0; i < 2; i++)
            begin
                n7_reg[i]  <= {dif7[i], {WB{1'b0}}};
                dn7_reg[i] <= sum7[i];
                z7_reg[i]  <= (sum7[i] == '0);
            end
        end
    end

    // ---------------- Twin divider: |x-y|/(x+y), one bit per stage ---------
    logic          d2_v_reg   [0:QW-1];
    logic          d2_tir_reg [0:QW-1];
    logic [NW-1:0] d2_rem_reg [0:QW-1][0:1];
    logic [QW-1:0] d2_q_reg   [0:QW-1][0:1];
    logic [DW-1:0] d2_dn_reg  [0:QW-1][0:1];
    logic          d2_z_reg   [0:QW-1][0:1];

    generate
        for (k = 0; k < QW; k++)
        begin : g_div2
            localparam int B = QW - 1 - k;
            logic v_i;
            logic tir_i;

            if (k == 0)
            begin : g_first
                assign v_i   = v7_reg;
                assign tir_i = tir7_reg;
            end
            else
            begin : g_next
                assign v_i   = d2_v_reg[k-1];
                assign tir_i = d2_tir_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    d2_v_reg[k] <= 1'b0;
                else if (adv)
                    d2_v_reg[k] <= v_i;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    d2_tir_reg[k] <= tir_i;
            end

            for (j = 0; j < 2; j++)
            begin : g_lane
                logic [NW-1:0] rem_i;
                logic [QW-1:0] q_i;
                logic [DW-1:0] dn_i;
                logic          z_i;
                logic [NW:0]   dsh;
                logic [NW:0]   remx;
                logic          ge;

                if (k == 0)
                begin : g_first
                    assign rem_i = n7_reg[j];
                    assign q_i   = '0;
                    assign dn_i  = dn7_reg[j];
                    assign z_i   = z7_reg[j];
                end
                else
                begin : g_next
                    assign rem_i = d2_rem_reg[k-1][j];
                    assign q_i   = d2_q_reg[k-1][j];
                    assign dn_i  = d2_dn_reg[k-1][j];
                    assign z_i   = d2_z_reg[k-1][j];
                end

                assign dsh  = (NW+1)'(dn_i) << B;
                assign remx = (NW+1)'(rem_i);
                assign ge   = remx >= dsh;

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        d2_rem_reg[k][j] <= ge ? NW'(remx - dsh) : rem_i;
                        d2_q_reg[k][j]   <= {q_i[QW-2:0], ge};
                        d2_dn_reg[k][j]  <= dn_i;
                        d2_z_reg[k][j]   <= z_i;
                    end
                end
            end
        end
    endgenerate

    // ---------------- Stage Q: square the amplitude ratios -----------------
    // An empty pair (x+y = 0) counts as ratio one, the grazing limit.
    logic [CW-1:0] r8 [0:1];
    always_comb
    begin
        for (int i = 0; i < 2; i++)
            r8[i] = d2_z_reg[QW-1][i] ? ONE_C : d2_q_reg[QW-1][i];
    end

    logic            v8_reg;
    logic            tir8_reg;
    logic [2*CW-1:0] sq8_reg [0:1];

    // ---------------- Stage O: average, saturate (one on TIR), widen -------
    logic [CW:0]   tot9;
    logic [CW-1:0] half9;
    logic [CW-1:0] refl9;

    always_comb
    begin
        tot9  = (CW+1)'(sq8_reg[0] >> WB) + (CW+1)'(sq8_reg[1] >> WB);
        half9 = CW'(tot9 >> 1);
        if (tir8_reg || half9 > ONE_C)
            refl9 = ONE_C;
        else
            refl9 = half9;
    end

    logic [FB:0] refl_reg;
    logic        tir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v8_reg    <= d2_v_reg[QW-1];
            out_v_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tir8_reg <= d2_tir_reg[QW-1];
            for (int i = 0; i < 2; i++)
                sq8_reg[i] <= (2*CW)'(r8[i]) * (2*CW)'(r8[i]);
            refl_reg <= (FB+1)'(refl9) << DROP;
            tir_reg  <= tir8_reg;
        end
    end

    assign result_valid   = out_v_reg;
    assign reflectance    = refl_reg;
    assign total_internal = tir_reg;

    // ---------------- Checks ------------------------------------------------
    `FDR_ASSERT_NOW(a_hold_on_stall, result_valid && result_stall, item_stall,
        "input taken while output word is held")
    `FDR_ASSERT_NOW(a_tir_is_one, result_valid && total_internal, reflectance == ONE_OUT,
        "total internal reflection without full reflectance")
    `FDR_ASSERT_NOW(a_refl_range, result_valid, reflectance <= ONE_OUT,
        "reflectance above one")
    `FDR_ASSERT_NEXT(a_word_held, result_valid && result_stall,
        result_valid && $stable(reflectance) && $stable(total_internal),
        "held output word changed")

endmodule

### tb/fresnel_dielectric_reflectance_core_tb.sv
// Self-checking testbench for the Fresnel reflectance core.
`timescale 1ns / 1ps

module fresnel_dielectric_reflectance_core_tb;

    localparam int FRAC_BITS = 16;
    localparam int WORK = FRAC_BITS < 24 ? FRAC_BITS : 24;
    localparam int DROP = FRAC_BITS - WORK;
    localparam int LATENCY = 3 * WORK + 15;
    localparam int RANDOM_WORDS = 1700;
    localparam logic [63:0] W_ONE = 64'd1 << WORK;
    localparam logic [63:0] F_ONE = 64'd1 << FRAC_BITS;

    typedef struct packed {
        logic [FRAC_BITS:0] refl;
        logic               tir;
    } reflect_t;

    typedef struct {
        logic signed [FRAC_BITS+1:0] cosv;
        logic [FRAC_BITS+3:0]        eta;
        bit                          typed;  // expected value typed in
        reflect_t                    want;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_stall;
    logic signed [FRAC_BITS+1:0] cos_incident;
    logic [FRAC_BITS+3:0]        rel_index;
    logic                        result_valid;
    logic                        result_stall;
    logic [FRAC_BITS:0]          reflectance;
    logic                        total_internal;

    reflect_t  pending_refl[$];
    stim_row_t directed[$];
    int        errors;

    fresnel_dielectric_reflectance_core #(.FRAC_BITS(FRAC_BITS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .cos_incident(cos_incident),
        .rel_index(rel_index),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .reflectance(reflectance),
        .total_internal(total_internal)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // ((x-y)/(x+y))^2, grazing limit of one when both are zero
    function automatic logic [63:0] amp_ratio_sq(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        if (x + y == 0)
            r = W_ONE;
        else
            r = ((x > y ? x - y : y - x) << WORK) / (x + y);
        return (r * r) >> WORK;
    endfunction

    function automatic reflect_t fresnel_reflect(input logic signed [FRAC_BITS+1:0] cosv,
                                                 input logic [FRAC_BITS+3:0] eta);
        longint      cs;
        bit          leaving;
        bit          tir;
        logic [63:0] e, c, s, a, ct, p2, g, t, rf;
        reflect_t    r;
        ct = 0;
        p2 = 0;
        e = 64'(eta) >> DROP;
        cs = longint'(cosv);
        if (cs > longint'(F_ONE))
            cs = longint'(F_ONE);
        if (cs < -longint'(F_ONE))
            cs = -longint'(F_ONE);
        leaving = cs < 0;
        c = 64'(leaving ? -cs : cs) >> DROP;
        s = W_ONE - ((c * c) >> WORK);
        a = (e * c) >> WORK;
        if (!leaving)
        begin
            tir = s * W_ONE >= e * e;
            if (!tir)
            begin
                g = root_floor(e * e - s * W_ONE);
                ct = (g << WORK) / e;
                p2 = g;
            end
        end
        else
        begin
            t = (s * ((e * e) >> WORK)) >> WORK;
            tir = t >= W_ONE;
            if (!tir)
            begin
                ct = root_floor((W_ONE - t) << WORK);
                p2 = (e * ct) >> WORK;
            end
        end
        if (tir)
        begin
            r.refl = F_ONE[FRAC_BITS:0];
            r.tir = 1'b1;
            return r;
        end
        rf = (amp_ratio_sq(a, ct) + amp_ratio_sq(c, p2)) >> 1;
        if (rf > W_ONE)
            rf = W_ONE;
        r.refl = (FRAC_BITS+1)'(rf << DROP);
        r.tir = 1'b0;
        return r;
    endfunction

    // mostly short gaps, sometimes long
    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(input int cv, input int ev, input bit typed, input reflect_t w);
        stim_row_t row;
        row.cosv = (FRAC_BITS+2)'(cv);
        row.eta = (FRAC_BITS+4)'(ev);
        row.typed = typed;
        row.want = w;
        directed.push_back(row);
    endtask

    // called at a falling edge; valid stays high into the next word unless a gap follows
    task automatic send_word(input logic signed [FRAC_BITS+1:0] cv,
                             input logic [FRAC_BITS+3:0] ev,
                             input bit typed, input reflect_t w);
        reflect_t predicted;
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        predicted = fresnel_reflect(cv, ev);
        if (typed && predicted !== w)
        begin
            $display("%0t: table row mismatch cos=%0d eta=%0d expected %h actual %h",
                     $time, cv, ev, w, predicted);
            errors++;
        end
        item_valid <= 1'b1;
        cos_incident <= cv;
        rel_index <= ev;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_refl.push_back(typed ? w : predicted);
        @(negedge clk);
    endtask

    // receiver stall pattern
    initial
    begin
        int gap;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = idle_gap();
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap)
                    @(negedge clk);
                result_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 20))
                @(negedge clk);
        end
    end

    // output checker
    always @(posedge clk)
    begin
        reflect_t got;
        reflect_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got.refl = reflectance;
            got.tir = total_internal;
            if (pending_refl.size() == 0)
            begin
                $display("%0t: unexpected word actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_refl.pop_front();
                if (got.refl !== want.refl)
                begin
                    $display("%0t: reflectance expected %0d actual %0d",
                             $time, want.refl, got.refl);
                    errors++;
                end
                if (got.tir !== want.tir)
                begin
                    $display("%0t: total_internal expected %0b actual %0b",
                             $time, want.tir, got.tir);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("[fresnel_dielectric_reflectance_core] ERROR");
        $finish;
    end

    initial
    begin
        reflect_t one_tir;
        reflect_t zero_r;
        reflect_t none;
        logic signed [FRAC_BITS+1:0] cv;
        logic [FRAC_BITS+3:0] ev;
        int p;
        errors = 0;
        item_valid = 1'b0;
        cos_incident = '0;
        rel_index = '0;
        rst_n = 1'b0;
        one_tir.refl = F_ONE[FRAC_BITS:0];
        one_tir.tir = 1'b1;
        zero_r.refl = '0;
        zero_r.tir = 1'b0;
        none = '0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        // directed table: extremes and special cases
        add_row(0, 0, 1, one_tir);           // zero index entering
        add_row(65536, 65536, 1, zero_r);    // matched index, normal incidence
        add_row(-65536, 65536, 1, zero_r);   // leaving, matched index
        add_row(0, 65536, 0, none);          // zero cosine, grazing
        add_row(131071, 98304, 0, none);     // cosine clamped from above
        add_row(-131072, 98304, 0, none);    // cosine clamped from below
        add_row(65536, 1048575, 0, none);
        add_row(65536, 4096, 0, none);
        add_row(-65536, 1048575, 0, none);
        add_row(-65536, 4096, 0, none);
        add_row(-1, 98304, 0, none);
        add_row(1, 98304, 0, none);
        add_row(-30000, 98304, 0, none);     // past the critical angle
        add_row(30000, 43690, 0, none);
        add_row(46341, 46341, 0, none);      // near the critical angle
        add_row(-46341, 92682, 0, none);
        add_row(0, 1048575, 0, none);
        add_row(-131072, 0, 0, none);
        add_row(131071, 1048575, 0, none);
        add_row(-2, 1, 0, none);
        foreach (directed[i])
            send_word(directed[i].cosv, directed[i].eta, directed[i].typed, directed[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            p = $urandom_range(0, 99);
            if (p < 80)
            begin
                cv = (FRAC_BITS+2)'($urandom_range(0, 131072) - 65536);
                ev = (FRAC_BITS+4)'($urandom_range(40000, 200000));
            end
            else
            begin
                cv = (FRAC_BITS+2)'($urandom);
                ev = (FRAC_BITS+4)'($urandom);
            end
            send_word(cv, ev, 0, none);
            if (n == RANDOM_WORDS / 2)
            begin
                // drain the pipeline once
                item_valid <= 1'b0;
                while (pending_refl.size() != 0)
                    @(negedge clk);
            end
        end
        item_valid <= 1'b0;
        while (pending_refl.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 20)
            @(negedge clk);
        if (errors == 0)
            $display("[fresnel_dielectric_reflectance_core] OK");
        else
            $display("[fresnel_dielectric_reflectance_core] ERROR");
        $finish;
    end

endmodule
